[rtl/core/sirs_pkg.sv]
package sirs_pkg;

  // Field and port widths fixed by the interface.
  localparam int VALUE_W     = 32;
  localparam int SYMBOL_W    = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = 5;
  localparam int TABLE_SIZE  = 16;
  localparam int TABLE_IDX_W = 4;
  localparam int RECIP_W     = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT = 2'd2;

  // Character codes used by the symbol check and the output.
  localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYMBOL_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CHAR_NONE  = 8'h00;

  // Configuration as seen by the conversion side.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] symbols_high;
    logic [CFG_DATA_W-1:0] symbols_low;
    logic [COUNT_W-1:0]    symbol_count;
  } cfg_t;

  // Symbol k of the 16-entry table, symbols 0 to 7 in the low word.
  function automatic logic [SYMBOL_W-1:0] sym_at(input cfg_t c,
                                                 input logic [TABLE_IDX_W-1:0] k);
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {c.symbols_high, c.symbols_low};
    return tbl[k*SYMBOL_W +: SYMBOL_W];
  endfunction

  // A usable digit symbol is printable, not space, and not a sign.
  function automatic logic symbol_ok(input logic [SYMBOL_W-1:0] ch);
    return (ch > CHAR_SPACE) && (ch <= CHAR_TILDE) &&
           (ch != CHAR_PLUS) && (ch != CHAR_MINUS);
  endfunction

  // Floor of 2^32 divided by the radix. The quotient estimate taken from
  // the upper product bits is the true quotient or one below it.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] r);
    logic [RECIP_W-1:0] res;
    case (r)
      5'd2:    res = 32'h8000_0000;
      5'd3:    res = 32'h5555_5555;
      5'd4:    res = 32'h4000_0000;
      5'd5:    res = 32'h3333_3333;
      5'd6:    res = 32'h2AAA_AAAA;
      5'd7:    res = 32'h2492_4924;
      5'd8:    res = 32'h2000_0000;
      5'd9:    res = 32'h1C71_C71C;
      5'd10:   res = 32'h1999_9999;
      5'd11:   res = 32'h1745_D174;
      5'd12:   res = 32'h1555_5555;
      5'd13:   res = 32'h13B1_3B13;
      5'd14:   res = 32'h1249_2492;
      5'd15:   res = 32'h1111_1111;
      5'd16:   res = 32'h1000_0000;
      default: res = 32'hFFFF_FFFF;
    endcase
    return res;
  endfunction

endpackage

[rtl/core/sirs_value_if.sv]
interface sirs_value_if import sirs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/sirs_symbol_if.sv]
interface sirs_symbol_if import sirs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                is_last;
  logic                base_error;

  modport source (output valid, output symbol, output is_last, output base_error,
                  input ready);
  modport sink   (input valid, input symbol, input is_last, input base_error,
                  output ready);
endinterface

[rtl/core/sirs_front.sv]
module sirs_front import sirs_pkg::*; #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sirs_value_if.sink             value_ch,
  input  logic                   full,
  output logic                   push,
  output logic [VALUE_BITS+1:0]  push_data,
  output cfg_t                   cfg
);

  typedef struct packed {
    logic                  err;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  cfg_t                  cfg_reg;
  logic                  base_ok;
  logic [VALUE_BITS-1:0] raw;
  item_t                 item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SYMBOLS_LOW:  cfg_reg.symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: cfg_reg.symbols_high <= cfg_data;
        REG_SYMBOL_COUNT: cfg_reg.symbol_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

  // Base check: count in range, every symbol in use printable, not space or a sign, and unique.
  always_comb begin
    base_ok = (cfg_reg.symbol_count >= COUNT_W'(2)) &&
              (cfg_reg.symbol_count <= COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (COUNT_W'(i) < cfg_reg.symbol_count) begin
        if (!symbol_ok(sym_at(cfg_reg, TABLE_IDX_W'(i)))) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((COUNT_W'(j) < cfg_reg.symbol_count) &&
              (sym_at(cfg_reg, TABLE_IDX_W'(i)) == sym_at(cfg_reg, TABLE_IDX_W'(j)))) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // Sign and magnitude; the most negative value keeps its top bit.
  always_comb begin
    raw      = value_ch.value[VALUE_BITS-1:0];
    item.err = !base_ok;
    item.neg = raw[VALUE_BITS-1];
    item.mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
  end

  // Accept a transaction whenever the queue has room.
  assign value_ch.ready = !full;
  assign push           = value_ch.valid && !full;
  assign push_data      = item;

endmodule

[rtl/core/sirs_queue.sv]
module sirs_queue import sirs_pkg::*; #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]       mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);

endmodule

[rtl/core/sirs_back.sv]
module sirs_back import sirs_pkg::*; #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  empty,
  input  logic [VALUE_BITS+1:0] pop_data,
  output logic                  pop,
  sirs_symbol_if.source         symbol_ch
);

  localparam int DIGIT_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int PTR_W   = $clog2(VALUE_BITS);
  localparam int PROD_W  = VALUE_BITS + RECIP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_ERR  = 3'd5;

  typedef struct packed {
    logic                  err;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  item_t                  head;
  logic [2:0]             state;
  logic [2:0]             state_next;
  logic                   neg;
  logic [VALUE_BITS-1:0]  mag;
  logic [VALUE_BITS-1:0]  q_est;
  logic [PTR_W-1:0]       ptr;
  logic [DIGIT_W-1:0]     digit_buffer [VALUE_BITS];
  logic [DIGIT_W-1:0]     cur_digit;
  logic [PROD_W-1:0]      prod;
  logic [VALUE_BITS+COUNT_W-1:0] qr;
  logic [VALUE_BITS-1:0]  rem_full;
  logic [COUNT_W-1:0]     rem;
  logic                   rem_over;
  logic [COUNT_W-1:0]     digit;
  logic [VALUE_BITS-1:0]  quot;
  logic                   slot_free;
  logic                   load;
  logic [SYMBOL_W-1:0]    load_symbol;
  logic                   load_last;
  logic                   load_err;
  logic                   out_valid;
  logic [SYMBOL_W-1:0]    out_symbol;
  logic                   out_last;
  logic                   out_err;

  assign head      = pop_data;
  assign slot_free = !out_valid || symbol_ch.ready;

  // Quotient estimate from the reciprocal of the radix.
  assign prod = {{RECIP_W{1'b0}}, mag} *
                {{VALUE_BITS{1'b0}}, recip_of(cfg.symbol_count)};

  // Remainder and the single correction step of the estimate.
  always_comb begin
    qr       = {{COUNT_W{1'b0}}, q_est} * {{VALUE_BITS{1'b0}}, cfg.symbol_count};
    rem_full = mag - qr[VALUE_BITS-1:0];
    rem      = rem_full[COUNT_W-1:0];
    rem_over = (rem >= cfg.symbol_count);
    digit    = rem_over ? (rem - cfg.symbol_count) : rem;
    quot     = rem_over ? (q_est + VALUE_BITS'(1)) : q_est;
  end

  // Sequencer: take a queue entry, split digits, then emit characters, or emit the base error transaction.
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load        = 1'b0;
    load_symbol = CHAR_NONE;
    load_last   = 1'b0;
    load_err    = 1'b0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = head.err ? S_ERR : S_MUL;
        end
      end
      S_MUL: state_next = S_FIX;
      S_FIX: begin
        if (quot == '0) begin
          state_next = neg ? S_SIGN : S_EMIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          load        = 1'b1;
          load_symbol = CHAR_MINUS;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load        = 1'b1;
          load_symbol = sym_at(cfg, TABLE_IDX_W'(cur_digit));
          load_last   = (ptr == '0);
          if (ptr == '0) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          load       = 1'b1;
          load_last  = 1'b1;
          load_err   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of one conversion.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        neg <= head.neg;
        mag <= head.mag;
        ptr <= '0;
      end
      S_MUL: q_est <= prod[PROD_W-1:RECIP_W];
      S_FIX: begin
        mag <= quot;
        if (quot != '0) begin
          ptr <= ptr + 1'b1;
        end
      end
      S_EMIT: begin
        if (slot_free && (ptr != '0)) begin
          ptr <= ptr - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Digit store, least significant digit at entry zero. The read is
  // registered: the digit just split is taken directly, and each emitted
  // character fetches the next lower digit.
  always_ff @(posedge clk) begin
    if (state == S_FIX) begin
      digit_buffer[ptr] <= digit[DIGIT_W-1:0];
      cur_digit         <= digit[DIGIT_W-1:0];
    end else if ((state == S_EMIT) && slot_free && (ptr != '0)) begin
      cur_digit <= digit_buffer[ptr - 1'b1];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (symbol_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_symbol <= load_symbol;
      out_last   <= load_last;
      out_err    <= load_err;
    end
  end

  assign symbol_ch.valid      = out_valid;
  assign symbol_ch.symbol     = out_symbol;
  assign symbol_ch.is_last    = out_last;
  assign symbol_ch.base_error = out_err;

endmodule

[rtl/core/signed_int_to_radix_symbols.sv]
// Converts a signed integer to its text in a radix of 2 to 16, most
// significant digit first, with a leading '-' for negative values, using
// the digit symbols written to the configuration registers. An invalid
// symbol table gives one transaction with base_error set and no text. The
// input side classifies each value into a two-entry queue, so up to two
// values are taken while a conversion is still running. The conversion unit
// handles one value at a time: it takes the value from the queue, runs the
// shared reciprocal multiply and correct step once per digit, then emits one
// character per cycle (sign included) when the output is not stalled.
module signed_int_to_radix_symbols import sirs_pkg::*; #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sirs_value_if.sink             value_ch,
  sirs_symbol_if.source          symbol_ch
);

  localparam int ITEM_W = VALUE_BITS + 2;

  cfg_t              cfg;
  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  logic [ITEM_W-1:0] push_data;
  logic [ITEM_W-1:0] pop_data;

  // Input side: configuration, base check and sign handling.
  sirs_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value_ch  (value_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  // Queue between classification and conversion.
  sirs_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // Conversion and character output.
  sirs_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .symbol_ch (symbol_ch)
  );

  // A base error is a single closing transaction with no character.
  assert property (@(posedge clk) disable iff (rst)
    symbol_ch.valid && symbol_ch.base_error |->
      symbol_ch.is_last && (symbol_ch.symbol == CHAR_NONE))
    else $error("base error transaction is malformed");

  // The conversion unit only takes entries that the queue holds.
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

  // Nothing is offered on the output right after reset.
  assert property (@(posedge clk) $past(rst) |-> !symbol_ch.valid)
    else $error("output valid right after reset");

endmodule
